// File: hdl/schema_token_lexer_macros.svh
// Assertion macros shared by the lexer's checker.
`ifndef SCHEMA_TOKEN_LEXER_MACROS_SVH
`define SCHEMA_TOKEN_LEXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// The consequent must hold in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// File: hdl/stl_pkg.sv
// Shared types, constants and character classes of the token lexer.
`default_nettype none
package stl_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_IDENT   = 4'd0;
    localparam kind_t KIND_NUMBER  = 4'd1;
    localparam kind_t KIND_EQUALS  = 4'd2;
    localparam kind_t KIND_COLON   = 4'd3;
    localparam kind_t KIND_SEMI    = 4'd4;
    localparam kind_t KIND_OPEN    = 4'd5;
    localparam kind_t KIND_CLOSE   = 4'd6;
    localparam kind_t KIND_DOT     = 4'd7;
    localparam kind_t KIND_PLUS    = 4'd8;
    localparam kind_t KIND_MINUS   = 4'd9;
    localparam kind_t KIND_TIMES   = 4'd10;
    localparam kind_t KIND_DIVIDE  = 4'd11;
    localparam kind_t KIND_MOD     = 4'd12;
    localparam kind_t KIND_COMMA   = 4'd13;
    localparam kind_t KIND_UNKNOWN = 4'd14;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } lex_mode_t;

    // One token character as it leaves the block.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] tbyte;
        logic       starts;
    } res_t;

    // All results caused by one input beat, in order.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } bundle_t;

    typedef struct packed {
        logic      emit;
        res_t      res;
        lex_mode_t mode;
        logic      dot;
    } idle_out_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h3D:   k = KIND_EQUALS;
            8'h3A:   k = KIND_COLON;
            8'h3B:   k = KIND_SEMI;
            8'h7B:   k = KIND_OPEN;
            8'h7D:   k = KIND_CLOSE;
            8'h2E:   k = KIND_DOT;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_TIMES;
            8'h2F:   k = KIND_DIVIDE;
            8'h25:   k = KIND_MOD;
            8'h2C:   k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Handling of a character met between tokens. A dot is held, not emitted.
    function automatic idle_out_t from_idle(input logic [7:0] c);
        idle_out_t o;
        o.emit       = 1'b0;
        o.res.kind   = punct_kind(c);
        o.res.tbyte  = c;
        o.res.starts = 1'b1;
        o.mode       = MODE_IDLE;
        o.dot        = 1'b0;
        if (is_blank(c))
        begin
            o.emit = 1'b0;
        end
        else if (is_ident_start(c))
        begin
            o.emit     = 1'b1;
            o.res.kind = KIND_IDENT;
            o.mode     = MODE_IDENT;
        end
        else if (is_digit(c))
        begin
            o.emit     = 1'b1;
            o.res.kind = KIND_NUMBER;
            o.mode     = MODE_NUMBER;
        end
        else if (c == CHAR_DOT)
        begin
            o.dot = 1'b1;
        end
        else
        begin
            o.emit = 1'b1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: hdl/stl_front.sv
// Front end: accepts characters, tracks lexer state and builds result bundles.
`default_nettype none
module stl_front
    import stl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       end_of_source,
    input  wire logic       q_ready,
    output logic            push,
    output bundle_t         push_data
);

    lex_mode_t mode_reg, mode_next;
    logic      dot_reg, dot_next;
    logic      accept;
    idle_out_t fi;
    logic [1:0] n;
    res_t      r0, r1;
    res_t      dot_res;
    res_t      cont_res;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    always_comb
    begin
        fi             = from_idle(char_in);
        dot_res.kind   = KIND_DOT;
        dot_res.tbyte  = CHAR_DOT;
        dot_res.starts = 1'b1;
        cont_res.kind   = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        cont_res.tbyte  = char_in;
        cont_res.starts = 1'b0;
        n         = 2'd0;
        r0        = fi.res;
        r1        = fi.res;
        mode_next = fi.mode;
        dot_next  = fi.dot;

        if (dot_reg)
        begin
            if (is_digit(char_in))
            begin
                // The held dot opens a number and the digit continues it.
                r0.kind   = KIND_NUMBER;
                r0.tbyte  = CHAR_DOT;
                r0.starts = 1'b1;
                r1.kind   = KIND_NUMBER;
                r1.tbyte  = char_in;
                r1.starts = 1'b0;
                n         = 2'd2;
                mode_next = MODE_NUMBER;
                dot_next  = 1'b0;
            end
            else
            begin
                r0 = dot_res;
                r1 = fi.res;
                n  = fi.emit ? 2'd2 : 2'd1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_ident_start(char_in) || is_digit(char_in))
                    begin
                        r0        = cont_res;
                        n         = 2'd1;
                        mode_next = MODE_IDENT;
                        dot_next  = 1'b0;
                    end
                    else
                    begin
                        n = {1'b0, fi.emit};
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(char_in) || char_in == CHAR_DOT)
                    begin
                        r0        = cont_res;
                        n         = 2'd1;
                        mode_next = MODE_NUMBER;
                        dot_next  = 1'b0;
                    end
                    else
                    begin
                        n = {1'b0, fi.emit};
                    end
                end
                default:
                begin
                    n = {1'b0, fi.emit};
                end
            endcase
        end

        // End of source flushes a held dot and returns to idle.
        if (end_of_source)
        begin
            if (dot_next)
            begin
                if (n == 2'd0)
                begin
                    r0 = dot_res;
                end
                else
                begin
                    r1 = dot_res;
                end
                n = n + 2'd1;
            end
            dot_next  = 1'b0;
            mode_next = MODE_IDLE;
        end
    end

    assign push           = accept && (n != 2'd0);
    assign push_data.cnt  = n;
    assign push_data.res0 = r0;
    assign push_data.res1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            dot_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            dot_reg  <= dot_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/stl_queue.sv
// Short bundle queue between the front end and the output stage.
`default_nettype none
module stl_queue
    import stl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    output logic         not_full,
    input  wire logic    pop,
    output logic         not_empty,
    output bundle_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bundle_t         mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign not_full  = cnt_reg != FULL_CNT;
    assign not_empty = cnt_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/stl_back.sv
// Output stage: holds one bundle and sends its results one beat at a time.
`default_nettype none
module stl_back
    import stl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_valid,
    input  wire bundle_t q_head,
    output logic         q_pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output res_t         out_res,
    output logic         out_last
);

    bundle_t cur_reg;
    logic    idx_reg;
    logic    valid_reg;
    logic    load;

    assign out_valid = valid_reg;
    assign out_res   = idx_reg ? cur_reg.res1 : cur_reg.res0;
    assign out_last  = (cur_reg.cnt == 2'd2) ? idx_reg : 1'b1;

    // A new bundle is taken when the stage is empty or its last beat leaves.
    assign load  = !valid_reg || (out_ready && out_last);
    assign q_pop = load && q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= q_valid;
            idx_reg   <= 1'b0;
        end
        else if (out_ready)
        begin
            idx_reg <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: hdl/schema_token_lexer.sv
// Accepts one character per cycle while the queue has room and streams tagged token characters.
// A result beat passes through the queue and the output stage register before it is offered.
// Throughput: one input beat per cycle while each input yields at most one result and m_tready
// stays high; an input yielding two results sends them one at a time on the single output port.
// Reset (rst_n low, asynchronous) clears lexer state, the queue and the output stage.
`default_nettype none
module schema_token_lexer
    import stl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_of_source
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] token_byte
    output logic [4:0]      m_tuser,   // [3:0] token_kind, [4] starts_token
    output logic            m_tlast    // last_result
);

    logic    push, q_not_full, q_not_empty, q_pop;
    bundle_t push_data, q_head;
    res_t    out_res;

    stl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .char_in       (s_tdata),
        .end_of_source (s_tlast),
        .q_ready       (q_not_full),
        .push          (push),
        .push_data     (push_data)
    );

    stl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    stl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tdata = out_res.tbyte;
    assign m_tuser = {out_res.starts, out_res.kind};

endmodule
`default_nettype wire

// File: hdl/stl_checker.sv
// Port-level checks on the lexer's output stream, bound to the top level.
`default_nettype none
`include "schema_token_lexer_macros.svh"
module stl_checker
    import stl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [4:0] m_tuser
);

    kind_t out_kind;
    logic  out_starts;
    logic  word_kind;
    logic  is_dot;
    logic  dot_char;
    logic  kind_ok;

    assign out_kind   = m_tuser[3:0];
    assign out_starts = m_tuser[4];
    assign word_kind  = (out_kind == KIND_IDENT) || (out_kind == KIND_NUMBER);
    assign is_dot     = m_tvalid && (out_kind == KIND_DOT);
    assign dot_char   = m_tdata == CHAR_DOT;
    assign kind_ok    = out_kind <= KIND_UNKNOWN;

    // A beat that is not taken stays offered.
    `STL_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // Only identifiers and numbers have continuation characters.
    `STL_ASSERT_SAME(a_cont_kind, clk, rst_n, m_tvalid && !out_starts, word_kind)

    // A dot token is always a starting '.' character.
    `STL_ASSERT_SAME(a_dot_token, clk, rst_n, is_dot, out_starts && dot_char)

    // Punctuation and unknown tokens are one character long.
    `STL_ASSERT_SAME(a_single_char, clk, rst_n, m_tvalid && !word_kind, out_starts && kind_ok)

endmodule

bind schema_token_lexer stl_checker u_stl_checker (.*);
`default_nettype wire

// File: dv/schema_token_lexer_tb.sv
// Self-checking testbench for the streaming token lexer.
`timescale 1ns / 1ps
`default_nettype none
module schema_token_lexer_tb;
    import stl_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } src_char_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tbyte;
        logic       starts;
        logic       last;
    } token_beat_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    src_char_t   source_chars[$];
    token_beat_t token_beats[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          chars_queued   = 0;

    // Lexer state as the predictor sees it.
    lex_mode_t scan_mode = MODE_IDLE;
    logic      dot_held  = 1'b0;

    schema_token_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic char_is_space(input logic [7:0] c);
        return c == " " || c inside {[8'h09:8'h0D]};
    endfunction

    function automatic logic char_is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic char_is_word_head(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic kind_t symbol_kind(input logic [7:0] c);
        case (c)
            "=":     return KIND_EQUALS;
            ":":     return KIND_COLON;
            ";":     return KIND_SEMI;
            "{":     return KIND_OPEN;
            "}":     return KIND_CLOSE;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_TIMES;
            "/":     return KIND_DIVIDE;
            "%":     return KIND_MOD;
            ",":     return KIND_COMMA;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    // A character seen between tokens; returns 1 when it produces a beat.
    function automatic logic open_token(input logic [7:0] c, output token_beat_t b);
        b = '{symbol_kind(c), c, 1'b1, 1'b0};
        scan_mode = MODE_IDLE;
        if (char_is_space(c))
            return 1'b0;
        if (char_is_word_head(c))
        begin
            b.kind = KIND_IDENT;
            scan_mode = MODE_IDENT;
        end
        else if (char_is_digit(c))
        begin
            b.kind = KIND_NUMBER;
            scan_mode = MODE_NUMBER;
        end
        else if (c == ".")
        begin
            dot_held = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the token beats caused by one accepted character.
    function automatic void lex_char(input logic [7:0] c, input logic eos);
        token_beat_t beats [3];
        token_beat_t b;
        int          n;
        n = 0;
        if (dot_held)
        begin
            dot_held = 1'b0;
            if (char_is_digit(c))
            begin
                beats[0] = '{KIND_NUMBER, ".", 1'b1, 1'b0};
                beats[1] = '{KIND_NUMBER, c, 1'b0, 1'b0};
                n = 2;
                scan_mode = MODE_NUMBER;
            end
            else
            begin
                beats[0] = '{KIND_DOT, ".", 1'b1, 1'b0};
                n = 1;
                if (open_token(c, b))
                begin
                    beats[n] = b;
                    n++;
                end
            end
        end
        else if (scan_mode == MODE_IDENT && (char_is_word_head(c) || char_is_digit(c)))
        begin
            beats[0] = '{KIND_IDENT, c, 1'b0, 1'b0};
            n = 1;
        end
        else if (scan_mode == MODE_NUMBER && (char_is_digit(c) || c == "."))
        begin
            beats[0] = '{KIND_NUMBER, c, 1'b0, 1'b0};
            n = 1;
        end
        else if (open_token(c, b))
        begin
            beats[0] = b;
            n = 1;
        end
        if (eos)
        begin
            if (dot_held)
            begin
                beats[n] = '{KIND_DOT, ".", 1'b1, 1'b0};
                n++;
            end
            dot_held = 1'b0;
            scan_mode = MODE_IDLE;
        end
        if (n > 0)
            beats[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            token_beats.insert(token_beats.size(), beats[i]);
    endfunction

    task automatic push_char(input logic [7:0] c, input logic eos);
        src_char_t sc;
        sc.ch  = c;
        sc.eos = eos;
        source_chars.insert(source_chars.size(), sc);
        chars_queued++;
    endtask

    task automatic push_text(input string s, input logic eos_at_end);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], eos_at_end && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_word_char(input logic with_digits);
        int r;
        r = $urandom_range(with_digits ? 62 : 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // One source text: mostly well-formed tokens, sometimes raw noise.
    task automatic push_source();
        logic [7:0] text[$];
        string      symbols;
        string      blanks;
        int         n_tokens;
        symbols = "=:;{}+-*/%,.";
        blanks  = " \t\n\v\f\r";
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 8))
                push_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            return;
        end
        n_tokens = $urandom_range(1, 6);
        repeat (n_tokens)
        begin
            case ($urandom_range(9))
                0, 1, 2, 9:
                begin
                    text.insert(text.size(), pick_word_char(1'b0));
                    repeat ($urandom_range(5))
                        text.insert(text.size(), pick_word_char(1'b1));
                    // An identifier running straight into a dot.
                    if ($urandom_range(3) == 0)
                        text.insert(text.size(), ".");
                end
                3, 4:
                begin
                    text.insert(text.size(), pick_digit());
                    repeat ($urandom_range(4))
                        text.insert(text.size(),
                                    ($urandom_range(3) == 0) ? "." : pick_digit());
                end
                5:
                begin
                    text.insert(text.size(), ".");
                    text.insert(text.size(), pick_digit());
                end
                6, 7:
                    text.insert(text.size(), symbols[$urandom_range(symbols.len() - 1)]);
                default:
                    text.insert(text.size(), 8'($urandom_range(255)));
            endcase
            if ($urandom_range(1) == 0)
                text.insert(text.size(), blanks[$urandom_range(blanks.len() - 1)]);
        end
        for (int i = 0; i < text.size(); i++)
            push_char(text[i], i == text.size() - 1);
    endtask

    task automatic drain_sources();
        while (source_chars.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        src_char_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                lex_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (source_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = source_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.eos;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        token_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (token_beats.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: beat with nothing expected: kind %0d byte %h starts %b last %b",
                             $realtime, m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
                end
                else
                begin
                    want = token_beats.pop_front();
                    if (m_tuser[3:0] != want.kind)
                    begin
                        mismatch_count++;
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $realtime, want.kind, m_tuser[3:0]);
                    end
                    if (m_tdata != want.tbyte)
                    begin
                        mismatch_count++;
                        $display("%0t: token_byte expected %h actual %h",
                                 $realtime, want.tbyte, m_tdata);
                    end
                    if (m_tuser[4] != want.starts)
                    begin
                        mismatch_count++;
                        $display("%0t: starts_token expected %b actual %b",
                                 $realtime, want.starts, m_tuser[4]);
                    end
                    if (m_tlast != want.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last_result expected %b actual %b",
                                 $realtime, want.last, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        int phase_end;
        send_pct = '{0, 63, 0, 22};
        recv_pct = '{0, 0, 63, 22};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Identifiers, a dot closing an identifier, numbers opened by a dot,
        // back-to-back dots, every symbol, blanks, control and high bytes,
        // and a dot flushed by the end of the source.
        push_text("Z_9.b\t.5.1 ..=:;{}+-*/%,", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h80, 1'b0);
        push_char(8'h7F, 1'b0);
        push_char(".", 1'b1);
        drain_sources();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            phase_end = chars_queued + 155;
            while (chars_queued < phase_end)
                push_source();
            drain_sources();
        end

        while (token_beats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/stl_pkg.sv
hdl/stl_front.sv
hdl/stl_queue.sv
hdl/stl_back.sv
hdl/schema_token_lexer.sv
hdl/stl_checker.sv
dv/schema_token_lexer_tb.sv
